>>> rtl/barrier_aware_bus_arbiter_core_assert.svh
// Assertion macros for the barrier-aware bus arbiter.
`ifndef BARRIER_AWARE_BUS_ARBITER_CORE_ASSERT_SVH
`define BARRIER_AWARE_BUS_ARBITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BAB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bab: property violated");
`define BAB_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("bab: forbidden condition seen");
`else
`define BAB_ASSERT(lbl, clk, rstn, prop)
`define BAB_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/bab_pkg.sv
// Package: types, constants and helpers of the barrier-aware bus arbiter.
package bab_pkg;

  localparam int NUM_CORES_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int OP_W          = 2;
  localparam int FADDR_W       = 16;
  localparam int DATA_W        = 32;
  localparam int CORE_FW       = 2;
  localparam int PRIO_W        = 4;
  localparam int NUM_PRIO_REGS = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int RANK_W        = 2;
  localparam int KEY_W         = RANK_W + PRIO_W;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_READ    = 2'd0;
  localparam op_t OP_WRITE   = 2'd1;
  localparam op_t OP_BARRIER = 2'd2;

  localparam logic [RANK_W-1:0] RANK_BARRIER = 2'd0;
  localparam logic [RANK_W-1:0] RANK_WRITE   = 2'd1;
  localparam logic [RANK_W-1:0] RANK_READ    = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [FADDR_W-1:0] address;
    logic [DATA_W-1:0]  data;
  } entry_t;

  typedef struct packed {
    logic               req_valid;
    logic [CORE_FW-1:0] req_core;
    op_t                req_op;
    logic [FADDR_W-1:0] req_address;
    logic [DATA_W-1:0]  req_data;
    logic               end_of_round;
  } req_t;

  typedef struct packed {
    logic               grant_valid;
    logic [CORE_FW-1:0] grant_core;
    op_t                grant_op;
    logic [FADDR_W-1:0] grant_address;
    logic [DATA_W-1:0]  grant_data;
    logic               grant_last;
    logic               barriers_cleared;
    logic               queue_overflow;
  } grant_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic             cand_valid;
    logic [KEY_W-1:0] cand_key;
    entry_t           cand_entry;
  } pick_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_SETTLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  function automatic logic [RANK_W-1:0] kind_rank(op_t op);
    logic [RANK_W-1:0] r;
    case (op)
      OP_BARRIER: r = RANK_BARRIER;
      OP_WRITE:   r = RANK_WRITE;
      default:    r = RANK_READ;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/bab_if.sv
// Valid/ready channel interfaces for request and grant items.
interface bab_req_if;
  logic           valid;
  logic           ready;
  bab_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bab_grant_if;
  logic            valid;
  logic            ready;
  bab_pkg::grant_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/bab_store.sv
// Request store: one-write, one-read memory holding all per-core queues.
module bab_store #(
  parameter int NUM_CORES   = bab_pkg::NUM_CORES_DEF,
  parameter int QUEUE_DEPTH = bab_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [$clog2(NUM_CORES*QUEUE_DEPTH)-1:0]    waddr_i,
  input  bab_pkg::entry_t                             wdata_i,
  input  logic                                        re_i,
  input  logic [$clog2(NUM_CORES*QUEUE_DEPTH)-1:0]    raddr_i,
  output bab_pkg::entry_t                             rdata_o
);

  localparam int ENTRIES = NUM_CORES * QUEUE_DEPTH;

  bab_pkg::entry_t mem_q [ENTRIES];
  bab_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bab_pick.sv
// Shared compare unit: keeps the smallest key seen over one scan of the cores.
module bab_pick #(
  parameter int NUM_CORES = bab_pkg::NUM_CORES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bab_pkg::pick_ctl_t            ctl_i,
  input  logic [$clog2(NUM_CORES)-1:0]  core_i,
  output logic                          best_valid_o,
  output logic [$clog2(NUM_CORES)-1:0]  best_core_o,
  output bab_pkg::entry_t               best_entry_o
);

  localparam int CORE_W = $clog2(NUM_CORES);

  logic                      best_valid_q;
  logic [bab_pkg::KEY_W-1:0] best_key_q;
  logic [CORE_W-1:0]         best_core_q;
  bab_pkg::entry_t           best_entry_q;
  logic                      take;

  // strict compare: cores are scanned upward, so a tie keeps the lower core
  assign take = ctl_i.step && ctl_i.cand_valid &&
                (!best_valid_q || (ctl_i.cand_key < best_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      best_valid_q <= 1'b0;
    end else if (take) begin
      best_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      best_key_q   <= ctl_i.cand_key;
      best_core_q  <= core_i;
      best_entry_q <= ctl_i.cand_entry;
    end
  end

  assign best_valid_o = best_valid_q;
  assign best_core_o  = best_core_q;
  assign best_entry_o = best_entry_q;

endmodule

>>> rtl/barrier_aware_bus_arbiter_core.sv
// Top level of the barrier-aware bus arbiter: queues, sequencer, output register.
//
//   channel   dir  handshake            carries
//   req_i     in   valid/ready          one request and/or round end
//   grant_o   out  valid/ready          one grant or empty-round marker
//   cfg       in   cfg_we_i (no wait)   core priority registers
//
// An item without round end is only enqueued into the store.
// An item with round end then pulls the queue heads out of the store
// and picks the grants one by one, each in a scan of the cores (one compare per
// cycle in the shared compare unit); an empty round emits a marker only.
// Reset clears pointers, flags and control; no clearing pass is needed.
// A stalled grant waits in the output register; the sequencer holds only
// when a further grant is ready and the register is still full.
`include "barrier_aware_bus_arbiter_core_assert.svh"

module barrier_aware_bus_arbiter_core #(
  parameter int NUM_CORES   = bab_pkg::NUM_CORES_DEF,
  parameter int QUEUE_DEPTH = bab_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bab_req_if.sink                         req_i,
  bab_grant_if.source                     grant_o,
  input  logic                            cfg_we_i,
  input  logic [bab_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bab_pkg::PRIO_W-1:0]      cfg_data_i
);

  localparam int CORE_W  = $clog2(NUM_CORES);
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_CORES * QUEUE_DEPTH;
  localparam int MEM_AW  = $clog2(ENTRIES);
  localparam int NCNT_W  = $clog2(NUM_CORES + 1);

  localparam logic [CORE_W-1:0] LAST_CORE = CORE_W'(NUM_CORES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  bab_pkg::state_e state_q, state_d;
  logic [CORE_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] head_q [NUM_CORES];
  logic [SLOT_W-1:0] tail_q [NUM_CORES];
  logic [CNT_W-1:0]  cnt_q  [NUM_CORES];
  logic [NUM_CORES-1:0] barrier_q, barrier_d;
  logic ovf_q, ovf_d;
  logic [bab_pkg::PRIO_W-1:0] prio_vec [NUM_CORES];
  logic [NUM_CORES-1:0] cand_valid_q, cand_valid_d;
  bab_pkg::entry_t cand_q [NUM_CORES];
  logic [NCNT_W-1:0] n_q, n_d;
  logic rd_pend_q;
  logic [CORE_W-1:0] rd_core_q;
  logic out_valid_q, out_valid_d;
  bab_pkg::grant_t out_q, grant_d;

  logic req_acc, op_ok, drop, enq_we, rd_en;
  logic [NUM_CORES-1:0] enq_hit, full_vec, take_vec, over_vec;
  logic [SLOT_W-1:0] tail_sel, head_sel;
  logic [CORE_W-1:0] enq_core;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  bab_pkg::entry_t wr_entry, rd_data;

  bab_pkg::pick_ctl_t pick_ctl;
  logic best_valid;
  logic [CORE_W-1:0] best_core;
  bab_pkg::entry_t best_entry;

  logic out_free, emit_fire, is_last, all_set, best_barrier;
  logic [NUM_CORES-1:0] best_onehot, flags_set;

  // ---------------------------------------------------------------- input side
  assign req_i.ready = (state_q == bab_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign op_ok       = req_i.payload.req_op inside
                       {bab_pkg::OP_READ, bab_pkg::OP_WRITE, bab_pkg::OP_BARRIER};

  for (genvar i = 0; i < NUM_CORES; i++) begin : g_core
    assign enq_hit[i]  = req_acc && req_i.payload.req_valid && op_ok &&
                         (int'(req_i.payload.req_core) == i);
    assign full_vec[i] = (cnt_q[i] == FULL_CNT);
    assign take_vec[i] = (state_q == bab_pkg::ST_GATHER) && (idx_q == CORE_W'(i)) &&
                         !barrier_q[i] && (cnt_q[i] != '0);
    assign over_vec[i] = (cnt_q[i] > FULL_CNT);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end else begin
        if (enq_hit[i] && !full_vec[i]) begin
          tail_q[i] <= (tail_q[i] == LAST_SLOT) ? '0 : tail_q[i] + 1'b1;
          cnt_q[i]  <= cnt_q[i] + 1'b1;
        end else if (take_vec[i]) begin
          head_q[i] <= (head_q[i] == LAST_SLOT) ? '0 : head_q[i] + 1'b1;
          cnt_q[i]  <= cnt_q[i] - 1'b1;
        end
      end
    end

    if (i < bab_pkg::NUM_PRIO_REGS) begin : g_prio_reg
      logic [bab_pkg::PRIO_W-1:0] prio_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          prio_q <= bab_pkg::PRIO_W'(i);
        end else if (cfg_we_i && (int'(cfg_idx_i) == i)) begin
          prio_q <= cfg_data_i;
        end
      end
      assign prio_vec[i] = prio_q;
    end else begin : g_prio_const
      assign prio_vec[i] = bab_pkg::PRIO_W'(i);
    end
  end

  assign drop   = |(enq_hit & full_vec);
  assign enq_we = |(enq_hit & ~full_vec);
  assign rd_en  = |take_vec;

  always_comb begin
    tail_sel = '0;
    head_sel = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (enq_hit[i]) tail_sel = tail_sel | tail_q[i];
      if (take_vec[i]) head_sel = head_sel | head_q[i];
    end
  end

  assign enq_core = CORE_W'(req_i.payload.req_core);
  assign wr_addr  = MEM_AW'(enq_core) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(tail_sel);
  assign rd_addr  = MEM_AW'(idx_q) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(head_sel);

  assign wr_entry.op      = req_i.payload.req_op;
  assign wr_entry.address = req_i.payload.req_address;
  assign wr_entry.data    = req_i.payload.req_data;

  bab_store #(
    .NUM_CORES   (NUM_CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (enq_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // queue heads pass through the store's read register into the candidate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_core_q <= idx_q;
    if (rd_pend_q) begin
      cand_q[rd_core_q] <= rd_data;
    end
  end

  // ---------------------------------------------------------------- compare unit
  assign pick_ctl.step       = (state_q == bab_pkg::ST_SCAN);
  assign pick_ctl.cand_valid = cand_valid_q[idx_q];
  assign pick_ctl.cand_key   = {bab_pkg::kind_rank(cand_q[idx_q].op), prio_vec[idx_q]};
  assign pick_ctl.cand_entry = cand_q[idx_q];
  assign pick_ctl.clear      = (state_q == bab_pkg::ST_SETTLE) || emit_fire;

  bab_pick #(
    .NUM_CORES (NUM_CORES)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pick_ctl),
    .core_i       (idx_q),
    .best_valid_o (best_valid),
    .best_core_o  (best_core),
    .best_entry_o (best_entry)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free  = !out_valid_q || grant_o.ready;
  assign emit_fire = (state_q == bab_pkg::ST_EMIT) && out_free;
  assign is_last   = (n_q <= NCNT_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      bab_pkg::ST_IDLE: begin
        if (req_acc && req_i.payload.end_of_round) state_d = bab_pkg::ST_GATHER;
      end
      bab_pkg::ST_GATHER: begin
        if (idx_q == LAST_CORE) state_d = bab_pkg::ST_SETTLE;
      end
      bab_pkg::ST_SETTLE: begin
        state_d = (n_q == '0) ? bab_pkg::ST_EMIT : bab_pkg::ST_SCAN;
      end
      bab_pkg::ST_SCAN: begin
        if (idx_q == LAST_CORE) state_d = bab_pkg::ST_EMIT;
      end
      bab_pkg::ST_EMIT: begin
        if (out_free) state_d = is_last ? bab_pkg::ST_IDLE : bab_pkg::ST_SCAN;
      end
      default: state_d = bab_pkg::ST_IDLE;
    endcase
  end

  assign best_onehot  = NUM_CORES'(1) << best_core;
  assign best_barrier = (n_q != '0) && (best_entry.op == bab_pkg::OP_BARRIER);
  assign flags_set    = barrier_q | (best_barrier ? best_onehot : '0);
  assign all_set      = &flags_set;

  always_comb begin
    idx_d = '0;
    if (((state_q == bab_pkg::ST_GATHER) || (state_q == bab_pkg::ST_SCAN)) &&
        (idx_q != LAST_CORE)) begin
      idx_d = idx_q + 1'b1;
    end

    n_d          = n_q;
    cand_valid_d = cand_valid_q | take_vec;
    barrier_d    = barrier_q;
    ovf_d        = ovf_q | drop;
    out_valid_d  = grant_o.ready ? 1'b0 : out_valid_q;

    grant_d                  = '0;
    grant_d.grant_last       = is_last;
    grant_d.barriers_cleared = is_last && all_set;
    grant_d.queue_overflow   = is_last && ovf_q;
    if (n_q != '0) begin
      grant_d.grant_valid   = 1'b1;
      grant_d.grant_core    = bab_pkg::CORE_FW'(best_core);
      grant_d.grant_op      = best_entry.op;
      grant_d.grant_address = best_entry.address;
      grant_d.grant_data    = best_entry.data;
    end

    if (rd_en) n_d = n_q + 1'b1;

    if (emit_fire) begin
      out_valid_d = 1'b1;
      barrier_d   = (is_last && all_set) ? '0 : flags_set;
      if (is_last) ovf_d = 1'b0;
      if (n_q != '0) begin
        n_d          = n_q - 1'b1;
        cand_valid_d = cand_valid_q & ~best_onehot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bab_pkg::ST_IDLE;
      idx_q        <= '0;
      n_q          <= '0;
      cand_valid_q <= '0;
      barrier_q    <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      n_q          <= n_d;
      cand_valid_q <= cand_valid_d;
      barrier_q    <= barrier_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q <= grant_d;
    end
  end

  assign grant_o.valid   = out_valid_q;
  assign grant_o.payload = out_q;

  // ---------------------------------------------------------------- checks
  `BAB_ASSERT(a_flags_not_all_idle, clk_i, rst_ni, (state_q == bab_pkg::ST_IDLE) |-> !(&barrier_q))
  `BAB_ASSERT(a_round_drained, clk_i, rst_ni, (state_q == bab_pkg::ST_IDLE) |-> (cand_valid_q == '0 && n_q == '0))
  `BAB_ASSERT(a_emit_has_best, clk_i, rst_ni, (state_q == bab_pkg::ST_EMIT && n_q != '0) |-> best_valid)
  `BAB_ASSERT_NEVER(a_queue_bound, clk_i, rst_ni, |over_vec)

endmodule
